>>> design/jsu_pkg.sv
// jsu_pkg: shared types, character codes and helper functions for the
// json string unescaper; no dependencies

package jsu_pkg;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = 3;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowU  = 8'h75;
  localparam logic [7:0] ChLowN  = 8'h6E;
  localparam logic [7:0] ChLowT  = 8'h74;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;

  localparam logic       StatusOk    = 1'b0;
  localparam logic       StatusUnterm = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       status;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] items;
    logic [CntW-1:0]   count;
  } batch_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      len;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } nibble_t;

  function automatic nibble_t hex_value(input logic [7:0] c);
    nibble_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok = 1'b1;
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok = 1'b1;
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok = 1'b1;
      r.value = 4'(c - 8'h37);
    end
    return r;
  endfunction

  function automatic utf8_t cp_to_utf8(input logic [15:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 16'h007F) begin
      r.len = 2'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp <= 16'h07FF) begin
      r.len = 2'd2;
      r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      r.len = 2'd3;
      r.bytes[0] = 8'hE0 | {4'h0, cp[15:12]};
      r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

  function automatic res_t data_res(input logic [7:0] b);
    res_t r;
    r.data = b;
    r.valid = 1'b1;
    r.last = 1'b0;
    r.status = StatusOk;
    return r;
  endfunction

  function automatic res_t end_res(input logic st);
    res_t r;
    r.data = 8'h00;
    r.valid = 1'b0;
    r.last = 1'b1;
    r.status = st;
    return r;
  endfunction

endpackage

>>> design/json_string_unescape_utf8.sv
// json_string_unescape_utf8: top level, json string body unescaper with
// utf-8 output of hex escapes; depends on jsu_pkg, jsu_decode, jsu_outbuf
// latency: the first result of a request appears in the cycle after acceptance
// throughput: one source byte per cycle while the result register is free; a byte
// giving several results, or a stalled output, holds the input while the result register drains
// reset: asynchronous, active low; clears escape state and pending results

module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       last_o,
  output logic       status_o
);

  logic            accept;
  logic            busy;
  jsu_pkg::batch_t batch;
  jsu_pkg::res_t   res;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .batch_o   (batch)
  );

  jsu_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .batch_i     (batch),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign out_byte_o   = res.data;
  assign byte_valid_o = res.valid;
  assign last_o       = res.last;
  assign status_o     = res.status;

endmodule

>>> design/jsu_decode.sv
// jsu_decode: escape state and decode of one source byte into a batch of
// up to four results; depends on jsu_pkg

module jsu_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     in_byte_i,
  output jsu_pkg::batch_t batch_o
);

  typedef enum logic [1:0] {
    ModeText = 2'd0,
    ModeEsc  = 2'd1,
    ModeHex  = 2'd2
  } mode_e;

  mode_e        mode_q, mode_d;
  logic [2:0]   hex_cnt_q, hex_cnt_d;
  logic [15:0]  cp_q, cp_d;

  jsu_pkg::nibble_t nib;
  jsu_pkg::utf8_t   enc;
  logic [15:0]      cp_new;
  logic             do_text;
  logic             do_utf8;
  logic [15:0]      enc_cp;
  jsu_pkg::batch_t  batch;
  logic [1:0]       pos;

  assign nib    = jsu_pkg::hex_value(in_byte_i);
  assign cp_new = {cp_q[11:0], nib.value};
  assign enc    = jsu_pkg::cp_to_utf8(enc_cp);

  always_comb begin
    mode_d    = mode_q;
    hex_cnt_d = hex_cnt_q;
    cp_d      = cp_q;
    do_text   = 1'b0;
    do_utf8   = 1'b0;
    enc_cp    = cp_q;
    batch     = '0;
    pos       = 2'd0;

    unique case (mode_q)
      ModeEsc: begin
        mode_d = ModeText;
        if (in_byte_i == jsu_pkg::ChNul) begin
          batch.items[0] = jsu_pkg::end_res(jsu_pkg::StatusUnterm);
          batch.count = 3'd1;
          hex_cnt_d = '0;
          cp_d = '0;
        end else if (in_byte_i == jsu_pkg::ChLowU) begin
          mode_d = ModeHex;
          hex_cnt_d = '0;
          cp_d = '0;
        end else if (in_byte_i == jsu_pkg::ChLowN) begin
          batch.items[0] = jsu_pkg::data_res(jsu_pkg::ChLf);
          batch.count = 3'd1;
        end else if (in_byte_i == jsu_pkg::ChLowT) begin
          batch.items[0] = jsu_pkg::data_res(jsu_pkg::ChTab);
          batch.count = 3'd1;
        end else begin
          batch.items[0] = jsu_pkg::data_res(in_byte_i);
          batch.count = 3'd1;
        end
      end
      ModeHex: begin
        if (nib.ok) begin
          cp_d = cp_new;
          hex_cnt_d = hex_cnt_q + 3'd1;
          if (hex_cnt_q == 3'd3) begin
            do_utf8 = 1'b1;
            enc_cp = cp_new;
            mode_d = ModeText;
            hex_cnt_d = '0;
            cp_d = '0;
          end
        end else begin
          do_utf8 = 1'b1;
          enc_cp = cp_q;
          mode_d = ModeText;
          hex_cnt_d = '0;
          cp_d = '0;
          do_text = 1'b1;
        end
      end
      default: begin
        do_text = 1'b1;
      end
    endcase

    if (do_utf8) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < enc.len) begin
          batch.items[i] = jsu_pkg::data_res(enc.bytes[i]);
        end
      end
      batch.count = {1'b0, enc.len};
      pos = enc.len;
    end

    if (do_text) begin
      if (in_byte_i == jsu_pkg::ChNul) begin
        batch.items[pos] = jsu_pkg::end_res(jsu_pkg::StatusUnterm);
        batch.count = {1'b0, pos} + 3'd1;
        mode_d = ModeText;
        hex_cnt_d = '0;
        cp_d = '0;
      end else if (in_byte_i == jsu_pkg::ChQuote) begin
        batch.items[pos] = jsu_pkg::end_res(jsu_pkg::StatusOk);
        batch.count = {1'b0, pos} + 3'd1;
        mode_d = ModeText;
        hex_cnt_d = '0;
        cp_d = '0;
      end else if (in_byte_i == jsu_pkg::ChBslash) begin
        mode_d = ModeEsc;
      end else begin
        batch.items[pos] = jsu_pkg::data_res(in_byte_i);
        batch.count = {1'b0, pos} + 3'd1;
        mode_d = ModeText;
      end
    end
  end

  assign batch_o = batch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeText;
      hex_cnt_q <= '0;
      cp_q      <= '0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      cp_q      <= cp_d;
    end
  end

endmodule

>>> design/jsu_outbuf.sv
// jsu_outbuf: result register holding one decoded batch and sending it out
// one result per request; depends on jsu_pkg

module jsu_outbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  jsu_pkg::batch_t batch_i,
  output logic            busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output jsu_pkg::res_t   res_o
);

  jsu_pkg::res_t [jsu_pkg::MaxRes-1:0] ent_q;
  logic [jsu_pkg::CntW-1:0]            left_q;
  logic [1:0]                          rd_q;
  logic                                take;

  assign out_valid_o = (left_q != '0);
  assign take        = out_valid_o && !out_stall_i;
  assign res_o       = ent_q[rd_q];
  // free once the last pending result leaves this cycle
  assign busy_o      = (left_q > 3'd1) || ((left_q == 3'd1) && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      rd_q   <= '0;
    end else if (load_i) begin
      left_q <= batch_i.count;
      rd_q   <= '0;
    end else if (take) begin
      left_q <= left_q - 3'd1;
      rd_q   <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= batch_i.items;
    end
  end

endmodule

>>> tb/jsu_checker.sv
`timescale 1ns / 100ps
// jsu_checker: watches both channels of the json string unescaper, predicts
// the decoded byte stream and compares every accepted result against it;
// depends on jsu_pkg
module jsu_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       byte_valid_i,
  input  logic       last_i,
  input  logic       status_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef enum logic [1:0] {ModeText, ModeEsc, ModeHex} esc_mode_e;

  esc_mode_e       mode_q   = ModeText;
  logic [2:0]      digits_q = '0;
  logic [15:0]     code_q   = '0;
  jsu_pkg::res_t   decoded_q[$];
  int              fails    = 0;

  task automatic push_byte(input logic [7:0] b);
    jsu_pkg::res_t r;
    r.data = b;
    r.valid = 1'b1;
    r.last = 1'b0;
    r.status = jsu_pkg::StatusOk;
    decoded_q.push_back(r);
  endtask

  task automatic clear_escape();
    mode_q = ModeText;
    digits_q = '0;
    code_q = '0;
  endtask

  task automatic end_string(input logic st);
    jsu_pkg::res_t r;
    r.data = jsu_pkg::ChNul;
    r.valid = 1'b0;
    r.last = 1'b1;
    r.status = st;
    clear_escape();
    decoded_q.push_back(r);
  endtask

  task automatic push_code_point(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      push_byte(cp[7:0]);
    end else if (cp < 16'h0800) begin
      push_byte({3'b110, cp[10:6]});
      push_byte({2'b10, cp[5:0]});
    end else begin
      push_byte({4'b1110, cp[15:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic plain_text(input logic [7:0] c);
    if (c == jsu_pkg::ChNul) begin
      end_string(jsu_pkg::StatusUnterm);
    end else if (c == jsu_pkg::ChQuote) begin
      end_string(jsu_pkg::StatusOk);
    end else if (c == jsu_pkg::ChBslash) begin
      mode_q = ModeEsc;
    end else begin
      mode_q = ModeText;
      push_byte(c);
    end
  endtask

  // top bit flags a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
    return '0;
  endfunction

  task automatic decode_byte(input logic [7:0] c);
    logic [4:0] h;
    h = hex_nibble(c);
    unique case (mode_q)
      ModeEsc: begin
        mode_q = ModeText;
        if (c == jsu_pkg::ChNul) begin
          end_string(jsu_pkg::StatusUnterm);
        end else if (c == jsu_pkg::ChLowU) begin
          clear_escape();
          mode_q = ModeHex;
        end else if (c == jsu_pkg::ChLowN) begin
          push_byte(jsu_pkg::ChLf);
        end else if (c == jsu_pkg::ChLowT) begin
          push_byte(jsu_pkg::ChTab);
        end else begin
          push_byte(c);
        end
      end
      ModeHex: begin
        if (h[4]) begin
          code_q = {code_q[11:0], h[3:0]};
          digits_q = digits_q + 3'd1;
          if (digits_q >= 3'd4) begin
            push_code_point(code_q);
            clear_escape();
          end
        end else begin
          // short escape: flush what was gathered, then treat as text
          push_code_point(code_q);
          clear_escape();
          plain_text(c);
        end
      end
      default: begin
        plain_text(c);
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    jsu_pkg::res_t want;
    if (!rst_ni) begin
      clear_escape();
    end else begin
      if (in_valid_i && !in_stall_i) decode_byte(in_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t unexpected result: byte %h valid %b last %b status %b",
                     $realtime, out_byte_i, byte_valid_i, last_i, status_i);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_i !== want.data || byte_valid_i !== want.valid ||
              last_i !== want.last || status_i !== want.status) begin
            fails++;
            if (fails <= 10)
              $display("%0t mismatch: expected %h %b %b %b, got %h %b %b %b",
                       $realtime, want.data, want.valid, want.last, want.status,
                       out_byte_i, byte_valid_i, last_i, status_i);
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o <= decoded_q.size();
  end

endmodule

>>> tb/tb_json_string_unescape_utf8.sv
`timescale 1ns / 100ps
// tb_json_string_unescape_utf8: drives json string bodies, escapes and noise
// into the unescaper under varying idle and stall patterns and gives the
// verdict; depends on jsu_pkg, jsu_checker and the block itself
module tb_json_string_unescape_utf8;

  localparam int HoldCycles    = 60;
  localparam int IdleLimit     = 1000;
  localparam int ItemsPerPhase = 110;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte    = 8'h00;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic       status;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  int holds_asked   = 0;
  int holds_done    = 0;
  int idle_cycles   = 0;
  int fail_count;
  int pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  json_string_unescape_utf8 DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .byte_valid_o(byte_valid),
    .last_o      (last),
    .status_o    (status)
  );

  jsu_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_byte_i  (out_byte),
    .byte_valid_i(byte_valid),
    .last_i      (last),
    .status_i    (status),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin : receiver
    int k;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        for (k = 0; k < HoldCycles; k++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request per call, returns once the handshake has happened
  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1));
    while (c == jsu_pkg::ChQuote || c == jsu_pkg::ChBslash);
    return c;
  endfunction

  function automatic logic [7:0] escape_stop();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1: return jsu_pkg::ChQuote;
      2: return jsu_pkg::ChBslash;
      3: return jsu_pkg::ChNul;
      default: begin
        do c = 8'($urandom_range(255, 1)); while (is_hex(c));
        return c;
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h007F, 0));
      1: return 16'($urandom_range(16'h07FF, 16'h0080));
      2: return 16'($urandom_range(16'hFFFF, 16'h0800));
      default: begin
        case ($urandom_range(5))
          0: return 16'h0000;
          1: return 16'h007F;
          2: return 16'h0080;
          3: return 16'h07FF;
          4: return 16'h0800;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic send_hex_escape(input int ndig, input logic [15:0] cp);
    int i;
    send_byte(jsu_pkg::ChBslash);
    send_byte(jsu_pkg::ChLowU);
    for (i = ndig - 1; i >= 0; i--) send_byte(hex_char(cp[4*i +: 4]));
    if (ndig < 4) send_byte(escape_stop());
  endtask

  task automatic send_string();
    int n;
    int kind;
    n = $urandom_range(12);
    repeat (n) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        send_byte(plain_char());
      end else if (kind < 55) begin
        send_byte(jsu_pkg::ChBslash);
        case ($urandom_range(5))
          0: send_byte(jsu_pkg::ChLowN);
          1: send_byte(jsu_pkg::ChLowT);
          2: send_byte(jsu_pkg::ChQuote);
          3: send_byte(jsu_pkg::ChBslash);
          4: send_byte("/");
          default: send_byte(8'($urandom_range(255, 1)));
        endcase
      end else if (kind < 80) begin
        send_hex_escape(4, pick_code_point());
      end else if (kind < 95) begin
        send_hex_escape($urandom_range(3), 16'($urandom));
      end else begin
        send_byte(jsu_pkg::ChBslash);
        send_byte(jsu_pkg::ChNul);
      end
    end
    send_byte(($urandom_range(99) < 85) ? jsu_pkg::ChQuote : jsu_pkg::ChNul);
  endtask

  initial begin
    int ph;
    int target;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'hFF);
    send_byte(jsu_pkg::ChBslash); send_byte(jsu_pkg::ChLowN);
    send_byte(jsu_pkg::ChBslash); send_byte(jsu_pkg::ChLowT);
    send_byte(jsu_pkg::ChBslash); send_byte(jsu_pkg::ChBslash);
    send_byte(jsu_pkg::ChBslash); send_byte(jsu_pkg::ChLowU);
    send_byte("0"); send_byte("7"); send_byte("f"); send_byte("F");
    send_byte(jsu_pkg::ChBslash); send_byte(jsu_pkg::ChLowU);
    send_byte("F"); send_byte("F"); send_byte("F"); send_byte("F");
    // short escape closed by a quote
    send_byte(jsu_pkg::ChBslash); send_byte(jsu_pkg::ChLowU);
    send_byte("7"); send_byte(jsu_pkg::ChQuote);
    send_byte(jsu_pkg::ChBslash); send_byte(jsu_pkg::ChNul);
    send_byte(jsu_pkg::ChNul);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          holds_asked <= holds_asked + 1;
        end
        1: begin
          send_idle_pct = 50;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 50;
        end
        default: begin
          send_idle_pct = 6;
          stall_pct = 6;
        end
      endcase
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) begin
        if ($urandom_range(9) == 0) begin
          n = $urandom_range(8, 1);
          repeat (n) send_byte(8'($urandom));
        end else begin
          send_string();
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
